>>> rtl/core/escape_rle_frame_run_decoder_top_defines.svh
// Assertion macros shared by the run decoder RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ESCAPE_RLE_FRAME_RUN_DECODER_TOP_DEFINES_SVH
`define ESCAPE_RLE_FRAME_RUN_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ERFRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("run decoder assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ERFRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("run decoder assertion failed");

`endif

>>> rtl/core/erfrd_pkg.sv
// Package for the escape run-length frame run decoder.
// Holds escape codes, fill bytes and field widths; no dependencies.
package erfrd_pkg;

   localparam int BYTE_W   = 8;
   localparam int HI_W     = 8;
   localparam int LO_W     = 7;
   localparam int COUNT_W  = HI_W + LO_W;
   localparam int OFFSET_W = 10;
   localparam int FRAMES_W = 6;

   localparam logic [BYTE_W-1:0] ESC_BLACK  = 8'h55;
   localparam logic [BYTE_W-1:0] ESC_WHITE  = 8'hAA;
   localparam logic [BYTE_W-1:0] FILL_BLACK = 8'h00;
   localparam logic [BYTE_W-1:0] FILL_WHITE = 8'hFF;

   typedef logic [HI_W-1:0] count_hi_type;
   typedef logic [LO_W-1:0] count_lo_type;
   typedef logic [FRAMES_W-1:0] frames_type;

endpackage

>>> rtl/core/erfrd_span.sv
// Frame position update for one run: new position and frame ends crossed.
// Depends on erfrd_pkg; instantiated by escape_rle_frame_run_decoder_top.
module erfrd_span
   import erfrd_pkg::*;
#(
   parameter int FRAME_BYTES = 1024,
   parameter int POS_W       = 10
) (
   input  logic [POS_W-1:0] start_pos,
   input  count_hi_type     count_hi,
   input  count_lo_type     count_lo,
   output logic [POS_W-1:0] next_pos,
   output frames_type       frames_done
);

   localparam int SUM_W   = POS_W + 2;
   localparam int HI_SPAN = 2 ** LO_W;

   // Quotient and remainder of each count half by the frame size, fixed at build time.
   // Only the low bits of the quotient are kept, as the frame count field wraps.
   frames_type       hi_q_tab [2**HI_W];
   logic [POS_W-1:0] hi_r_tab [2**HI_W];
   frames_type       lo_q_tab [2**LO_W];
   logic [POS_W-1:0] lo_r_tab [2**LO_W];

   for (genvar i = 0; i < 2**HI_W; i++) begin : g_hi_tab
      assign hi_q_tab[i] = FRAMES_W'((i * HI_SPAN) / FRAME_BYTES);
      assign hi_r_tab[i] = POS_W'((i * HI_SPAN) % FRAME_BYTES);
   end

   for (genvar j = 0; j < 2**LO_W; j++) begin : g_lo_tab
      assign lo_q_tab[j] = FRAMES_W'(j / FRAME_BYTES);
      assign lo_r_tab[j] = POS_W'(j % FRAME_BYTES);
   end

   logic [SUM_W-1:0] rem_sum;
   logic [SUM_W-1:0] rem_fold;
   frames_type       carry;

   // The three remainders add to less than three frames, so one compare chain folds them.
   always_comb begin
      rem_sum = SUM_W'(start_pos) + SUM_W'(hi_r_tab[count_hi]) + SUM_W'(lo_r_tab[count_lo]);
      priority if (rem_sum >= SUM_W'(2 * FRAME_BYTES)) begin
         rem_fold = rem_sum - SUM_W'(2 * FRAME_BYTES);
         carry    = FRAMES_W'(2);
      end else if (rem_sum >= SUM_W'(FRAME_BYTES)) begin
         rem_fold = rem_sum - SUM_W'(FRAME_BYTES);
         carry    = FRAMES_W'(1);
      end else begin
         rem_fold = rem_sum;
         carry    = '0;
      end
   end

   assign next_pos    = rem_fold[POS_W-1:0];
   assign frames_done = hi_q_tab[count_hi] + lo_q_tab[count_lo] + carry;

endmodule

>>> rtl/core/escape_rle_frame_run_decoder_top.sv
// Top level of the escape run-length frame run decoder.
// Depends on erfrd_pkg, erfrd_span and the assertion macro header.

// The decoder takes one byte of an escape-coded run-length stream per item
// on the req_ channel and returns at most one run descriptor per byte on the
// rsp_ channel. A byte other than 0x55 or 0xAA is a literal and yields a run
// of count one. The escape 0x55 opens a run of 0x00 bytes and 0xAA a run of
// 0xFF bytes; the byte after it is zero for the escape byte itself, 1 to 127
// for a short count, or 128 and above for the low seven bits of a long count
// whose high eight bits follow in the next byte. A long count of zero yields
// nothing. Each descriptor carries the byte value, the count, the frame byte
// offset of its first byte and the number of frame ends the run crosses; the
// decoder keeps its own write position in the frame, starting at the top
// left after reset. The block takes one byte per clock cycle while the
// result register is free or being emptied. A byte passes from the input
// register to the result register, where its result, if any, is presented.
// The clock speed is bounded by the frame position loop, which
// combinationally looks up the count halves in two constant tables, adds
// three remainders and folds the sum back into the frame with a two-way
// compare and subtract. While a result waits to be taken, the input
// register can still take one more byte; after that the input stalls until
// the result register is emptied.
`include "escape_rle_frame_run_decoder_top_defines.svh"

module escape_rle_frame_run_decoder_top
   import erfrd_pkg::*;
#(
   parameter int FRAME_WIDTH  = 128,
   parameter int FRAME_HEIGHT = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_rle_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [BYTE_W-1:0]   rsp_run_value,
   output logic [COUNT_W-1:0]  rsp_run_count,
   output logic [OFFSET_W-1:0] rsp_start_offset,
   output logic [FRAMES_W-1:0] rsp_frames_done
);

   // Frame size in bytes; a frame narrower than one byte group counts as one byte.
   localparam int FRAME_BYTES_RAW = (FRAME_WIDTH / 8) * FRAME_HEIGHT;
   localparam int FRAME_BYTES     = (FRAME_BYTES_RAW == 0) ? 1 : FRAME_BYTES_RAW;
   localparam int POS_W           = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
   localparam int EXT_W           = POS_W + OFFSET_W;

   // Input register.
   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;

   // Decoder state.
   logic               esc_seen_ff, esc_seen_in;
   logic               esc_white_ff, esc_white_in;
   logic               long_pend_ff, long_pend_in;
   count_lo_type       low_bits_ff, low_bits_in;
   logic [POS_W-1:0]   pos_ff, pos_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_value_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   frames_type         rsp_frames_ff;

   logic               advance;
   logic               emit;
   logic [BYTE_W-1:0]  run_value;
   count_hi_type       count_hi;
   count_lo_type       count_lo;
   logic [POS_W-1:0]   span_pos;
   frames_type         span_frames;
   logic [EXT_W-1:0]   pos_ext;

   // The byte in the input register moves on whenever the result register is
   // free or is being emptied in this cycle, even if the byte yields no run.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Byte decode. Every count is split into a high byte and low seven bits,
   // so literals and short counts simply have a zero high part.
   always_comb begin
      emit         = 1'b0;
      run_value    = in_byte_ff;
      count_hi     = '0;
      count_lo     = count_lo_type'(1);
      esc_seen_in  = esc_seen_ff;
      esc_white_in = esc_white_ff;
      long_pend_in = long_pend_ff;
      low_bits_in  = low_bits_ff;
      priority if (!esc_seen_ff) begin
         if (in_byte_ff == ESC_BLACK || in_byte_ff == ESC_WHITE) begin
            esc_seen_in  = 1'b1;
            esc_white_in = (in_byte_ff == ESC_WHITE);
         end else begin
            emit = 1'b1;
         end
      end else if (!long_pend_ff) begin
         if (in_byte_ff == '0) begin
            // Escaped escape: the escape byte itself, once.
            emit        = 1'b1;
            run_value   = esc_white_ff ? ESC_WHITE : ESC_BLACK;
            esc_seen_in = 1'b0;
         end else if (!in_byte_ff[BYTE_W-1]) begin
            emit        = 1'b1;
            run_value   = esc_white_ff ? FILL_WHITE : FILL_BLACK;
            count_lo    = in_byte_ff[LO_W-1:0];
            esc_seen_in = 1'b0;
         end else begin
            long_pend_in = 1'b1;
            low_bits_in  = in_byte_ff[LO_W-1:0];
         end
      end else begin
         // Second byte of a long count; a count of zero closes the escape silently.
         emit         = (in_byte_ff != '0) || (low_bits_ff != '0);
         run_value    = esc_white_ff ? FILL_WHITE : FILL_BLACK;
         count_hi     = in_byte_ff;
         count_lo     = low_bits_ff;
         esc_seen_in  = 1'b0;
         long_pend_in = 1'b0;
         low_bits_in  = '0;
      end
   end

   erfrd_span #(
      .FRAME_BYTES (FRAME_BYTES),
      .POS_W       (POS_W)
   ) u_span (
      .start_pos   (pos_ff),
      .count_hi    (count_hi),
      .count_lo    (count_lo),
      .next_pos    (span_pos),
      .frames_done (span_frames)
   );

   assign pos_ext = EXT_W'(pos_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      pos_in = (advance && emit) ? span_pos : pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         esc_seen_ff  <= 1'b0;
         esc_white_ff <= 1'b0;
         long_pend_ff <= 1'b0;
         low_bits_ff  <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         if (advance) begin
            esc_seen_ff  <= esc_seen_in;
            esc_white_ff <= esc_white_in;
            long_pend_ff <= long_pend_in;
            low_bits_ff  <= low_bits_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rle_byte;
      end
      if (advance && emit) begin
         rsp_value_ff  <= run_value;
         rsp_count_ff  <= {count_hi, count_lo};
         rsp_offset_ff <= pos_ext[OFFSET_W-1:0];
         rsp_frames_ff <= span_frames;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_run_value    = rsp_value_ff;
   assign rsp_run_count    = rsp_count_ff;
   assign rsp_start_offset = rsp_offset_ff;
   assign rsp_frames_done  = rsp_frames_ff;

   // A long count can only be pending inside an escape.
   `ERFRD_ASSERT_NOW(a_long_needs_escape, clock, reset, long_pend_ff, esc_seen_ff)
   // The write position always stays inside the frame.
   `ERFRD_ASSERT_NOW(a_pos_in_frame, clock, reset, 1'b1, 32'(pos_ff) < FRAME_BYTES)
   // No run of count zero ever reaches the output.
   `ERFRD_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid_ff, rsp_count_ff != '0)
   // A literal byte outside an escape always yields a result in the next cycle.
   `ERFRD_ASSERT_NEXT(a_literal_emits, clock, reset,
      advance && !esc_seen_ff && in_byte_ff != ESC_BLACK && in_byte_ff != ESC_WHITE,
      rsp_valid_ff)
   // The second byte of a long count always closes the escape.
   `ERFRD_ASSERT_NEXT(a_long_closes, clock, reset, advance && long_pend_ff,
      !esc_seen_ff && !long_pend_ff)

endmodule

>>> bench/escape_rle_frame_run_decoder_top_tb.sv
// Self-checking bench for escape_rle_frame_run_decoder_top.
// Needs erfrd_pkg and the decoder RTL. Bytes of the coded stream go in on
// req_ and predicted run descriptors are checked against those on rsp_.
module escape_rle_frame_run_decoder_top_tb;
   import erfrd_pkg::*;

   localparam int FRAME_WIDTH  = 128;
   localparam int FRAME_HEIGHT = 64;
   localparam int FRAME_BYTES  = (FRAME_WIDTH / 8) * FRAME_HEIGHT;

   // The byte after an escape that asks for the escape byte itself.
   localparam logic [BYTE_W-1:0] ESC_SELF = 8'h00;

   // Burst idling stops once fewer than this many bytes are left to send.
   localparam int QUIET_TAIL_BYTES = 100;
   localparam int RANDOM_BYTES     = 700;

   typedef struct {
      logic [BYTE_W-1:0] value;
      bit                hold_for_drain;
   } coded_byte_type;

   typedef struct {
      logic [BYTE_W-1:0]   value;
      logic [COUNT_W-1:0]  count;
      logic [OFFSET_W-1:0] offset;
      frames_type          frames;
   } run_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [BYTE_W-1:0]   req_rle_byte = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_run_value;
   logic [COUNT_W-1:0]  rsp_run_count;
   logic [OFFSET_W-1:0] rsp_start_offset;
   logic [FRAMES_W-1:0] rsp_frames_done;

   coded_byte_type stream_bytes[$];
   run_type        runs_due[$];
   int             mismatches = 0;

   // Handshake flags taken at the rising edge and used by the falling-edge
   // drivers, so that neither side reads a value the other side is changing.
   logic byte_accepted = 1'b0;
   logic quiet_tail    = 1'b0;

   // The decoder state as the bench sees it.
   bit                esc_pending  = 1'b0;
   bit                esc_white    = 1'b0;
   bit                long_pending = 1'b0;
   count_lo_type      count_lo     = '0;
   int unsigned       frame_pos    = 0;

   escape_rle_frame_run_decoder_top #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .FRAME_HEIGHT(FRAME_HEIGHT)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rle_byte    (req_rle_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_run_value   (rsp_run_value),
      .rsp_run_count   (rsp_run_count),
      .rsp_start_offset(rsp_start_offset),
      .rsp_frames_done (rsp_frames_done)
   );

   always #5 clock = ~clock;

   // Queues one descriptor and moves the write position on by its count. The
   // position wraps at the frame size, and the number of wraps is the count
   // of frame ends that the run crosses.
   function automatic void add_run(input logic [BYTE_W-1:0] value,
                                   input int unsigned count);
      run_type     r;
      int unsigned end_pos;
      end_pos  = frame_pos + count;
      r.value  = value;
      r.count  = count[COUNT_W-1:0];
      r.offset = frame_pos[OFFSET_W-1:0];
      r.frames = frames_type'(end_pos / FRAME_BYTES);
      runs_due.push_back(r);
      frame_pos = end_pos % FRAME_BYTES;
   endfunction

   // Steps the decoder state by one accepted byte and queues the run that it
   // completes, if any.
   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] fill;
      int unsigned       count;
      fill = esc_white ? FILL_WHITE : FILL_BLACK;
      if (!esc_pending) begin
         if (b == ESC_BLACK || b == ESC_WHITE) begin
            esc_pending = 1'b1;
            esc_white   = (b == ESC_WHITE);
         end else begin
            add_run(b, 1);
         end
      end else if (!long_pending) begin
         if (b == ESC_SELF) begin
            esc_pending = 1'b0;
            add_run(esc_white ? ESC_WHITE : ESC_BLACK, 1);
         end else if (!b[BYTE_W-1]) begin
            esc_pending = 1'b0;
            add_run(fill, 32'(b));
         end else begin
            long_pending = 1'b1;
            count_lo     = b[LO_W-1:0];
         end
      end else begin
         count        = 32'({b, count_lo});
         esc_pending  = 1'b0;
         long_pending = 1'b0;
         count_lo     = '0;
         // A long count of zero closes the escape without a run.
         if (count != 0)
            add_run(fill, count);
      end
   endfunction

   function automatic void check_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   function automatic void queue_byte(input logic [BYTE_W-1:0] value,
                                      input bit hold_for_drain = 1'b0);
      coded_byte_type c;
      c.value          = value;
      c.hold_for_drain = hold_for_drain;
      stream_bytes.push_back(c);
   endfunction

   // Monitor: at each rising edge the accepted byte, if any, is run through
   // the predictor, and an accepted result is checked against the oldest
   // descriptor still due. Each result is registered behind its byte, so
   // pushing before popping here never matches a byte with its own result.
   always @(posedge clock) begin
      run_type want;
      byte_accepted <= !reset && req_valid && req_ready;
      quiet_tail    <= stream_bytes.size() < QUIET_TAIL_BYTES;
      if (!reset) begin
         if (req_valid && req_ready)
            decode_byte(req_rle_byte);
         if (rsp_valid && rsp_ready) begin
            if (runs_due.size() == 0) begin
               $display("%0t: run descriptor with none expected: value %0d count %0d",
                        $time, rsp_run_value, rsp_run_count);
               mismatches++;
            end else begin
               want = runs_due.pop_front();
               check_field("run_value", 32'(want.value), 32'(rsp_run_value));
               check_field("run_count", 32'(want.count), 32'(rsp_run_count));
               check_field("start_offset", 32'(want.offset), 32'(rsp_start_offset));
               check_field("frames_done", 32'(want.frames), 32'(rsp_frames_done));
            end
         end
      end
   end

   // Driver: a byte once offered is held until it has been taken. Between
   // bytes the sender may idle in random bursts, and a byte marked for a
   // drain is held back until every predicted run has arrived.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !byte_accepted)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (stream_bytes.size() == 0) begin
            req_valid <= 1'b0;
         end else if (stream_bytes[0].hold_for_drain && runs_due.size() != 0) begin
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap  = $urandom_range(0, 2);
            req_valid <= 1'b0;
         end else begin
            req_valid    <= 1'b1;
            req_rle_byte <= stream_bytes[0].value;
            void'(stream_bytes.pop_front());
         end
      end
   end

   // Receiver: stalls in random bursts, none in the tail.
   int stall_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         stall_gap = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Stimulus and end of run.
   initial begin
      int          sent;
      int          pick;
      logic [BYTE_W-1:0] esc;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      bit          drained;
      bit          hold;

      // Literals at the edges of the byte range and next to both escapes.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(8'h54);
      queue_byte(8'h56);
      queue_byte(8'hA9);
      queue_byte(8'hAB);
      // Each escape asking for itself.
      queue_byte(ESC_BLACK); queue_byte(ESC_SELF);
      queue_byte(ESC_WHITE); queue_byte(ESC_SELF);
      // Shortest and longest short counts.
      queue_byte(ESC_BLACK); queue_byte(8'h01);
      queue_byte(ESC_WHITE); queue_byte(8'h7F);
      // A long count of zero, which yields nothing.
      queue_byte(ESC_BLACK); queue_byte(8'h80); queue_byte(8'h00);
      // The largest long count, which wraps the frame many times over.
      queue_byte(ESC_WHITE); queue_byte(8'hFF); queue_byte(8'hFF);
      // Long counts of one and of 128.
      queue_byte(ESC_WHITE); queue_byte(8'h81); queue_byte(8'h00);
      queue_byte(ESC_BLACK); queue_byte(8'h80); queue_byte(8'h01);

      // Random part: well-formed escape sequences mixed with literals.
      // Halfway through, the sender waits for the decoder to drain once.
      sent    = 0;
      drained = 1'b0;
      while (sent < RANDOM_BYTES) begin
         hold = !drained && sent >= RANDOM_BYTES / 2;
         if (hold)
            drained = 1'b1;
         pick = $urandom_range(0, 9);
         esc  = $urandom_range(0, 1) ? ESC_WHITE : ESC_BLACK;
         if (pick < 5) begin
            lo = BYTE_W'($urandom_range(0, 255));
            if (lo == ESC_BLACK || lo == ESC_WHITE)
               lo[0] = ~lo[0];
            queue_byte(lo, hold);
            sent += 1;
         end else begin
            queue_byte(esc, hold);
            if (pick == 5) begin
               queue_byte(ESC_SELF);
               sent += 2;
            end else if (pick < 8) begin
               queue_byte(BYTE_W'($urandom_range(1, 127)));
               sent += 2;
            end else begin
               lo = {1'b1, 7'($urandom_range(0, 127))};
               hi = BYTE_W'($urandom_range(0, 255));
               if ($urandom_range(0, 7) == 0) begin
                  lo = 8'h80;
                  hi = 8'h00;
               end
               queue_byte(lo);
               queue_byte(hi);
               sent += 3;
            end
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0 || req_valid)
         @(posedge clock);
      while (runs_due.size() != 0)
         @(posedge clock);
      // Wait on to catch any stray descriptor.
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("escape_rle_frame_run_decoder_top_tb: done, clean");
      else
         $display("escape_rle_frame_run_decoder_top_tb: done, errors");
      $finish;
   end

   // Watchdog, far beyond the slowest run with every burst at its longest.
   initial begin
      #2000000;
      $display("escape_rle_frame_run_decoder_top_tb: done, errors");
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/erfrd_pkg.sv
rtl/core/erfrd_span.sv
rtl/core/escape_rle_frame_run_decoder_top.sv
bench/escape_rle_frame_run_decoder_top_tb.sv
